[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the line framer.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check on the rising edge of clk.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a rising edge of clk.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/core/clf_pkg.sv]
// Package for the CR LF line framer: payload structs, codes and constants.
// Used by every module of the block; depends on nothing.
package clf_pkg;

  localparam int BUFFER_BYTES_DEF = 64;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int LIMIT_W    = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENDING_LIMIT = 8'd1;

  localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST  = 16'd100;
  localparam logic [LIMIT_W-1:0]   PENDING_LIMIT_RST = 7'd56;

  localparam logic       CMD_BYTE = 1'b0;
  localparam logic       CMD_TICK = 1'b1;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
  } out_item_t;

endpackage

[rtl/core/clf_line_store.sv]
// Line store of the framer: one write port and one registered read port.
// Depends on clf_pkg for the default depth.
module clf_line_store
  import clf_pkg::*;
#(
  parameter int DEPTH = BUFFER_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/crlf_line_framer_top.sv]
// CR LF line framer, top level; uses clf_pkg, clf_line_store and assert_macros.svh.
// Each input word is a received byte or a millisecond tick, and every byte is
// written into a line memory of BUFFER_BYTES entries. When LF follows CR, the
// whole line is read back and sent out one byte per output word, with
// line_end on the LF. While a finished line is read out, the input is stalled,
// and the stall lasts longer while out_ready is held low, since each byte
// needs one read of the single memory read port and one load of the output
// register; the last byte may still sit in the output register while the next
// input word is accepted. A byte that arrives after more than idle_timeout_ticks
// ticks drops the partial line first; an unfinished line longer than
// pending_limit (capped at BUFFER_BYTES - 1) is dropped silently. No clearing
// pass is needed after reset.
`include "assert_macros.svh"

module crlf_line_framer_top
  import clf_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = $clog2(BUFFER_BYTES);
  localparam int CNTW = $clog2(BUFFER_BYTES + 1);
  localparam int CMPW = (CNTW > LIMIT_W) ? CNTW : LIMIT_W;
  localparam logic [CMPW-1:0] CAP = CMPW'(BUFFER_BYTES - 1);

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          fill_count_r, fill_count_nxt;
  logic [TIMEOUT_W-1:0]   idle_ticks_r, idle_ticks_nxt;
  logic                   prior_cr_r, prior_cr_nxt;
  logic [TIMEOUT_W-1:0]   idle_timeout_r, idle_timeout_nxt;
  logic [LIMIT_W-1:0]     pending_limit_r, pending_limit_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic                   rd_last_r, rd_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [AW-1:0]          rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]          last_idx_r, last_idx_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic                   in_fire;
  logic                   is_byte;
  logic                   timed_out;
  logic [AW-1:0]          base_fill;
  logic                   base_cr;
  logic [CMPW-1:0]        new_fill;
  logic [CMPW-1:0]        eff_limit;
  logic                   line_done;
  logic                   rd_en;
  logic [7:0]             rd_data;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign in_fire   = in_valid && in_ready;
  assign is_byte   = (in_item.cmd == CMD_BYTE);
  assign timed_out = (idle_ticks_r > idle_timeout_r);
  assign base_fill = timed_out ? '0 : fill_count_r;
  assign base_cr   = timed_out ? 1'b0 : prior_cr_r;
  assign new_fill  = CMPW'(base_fill) + CMPW'(1);
  assign eff_limit = (CMPW'(pending_limit_r) < CAP) ? CMPW'(pending_limit_r) : CAP;
  assign line_done = (in_item.rx_byte == CHAR_LF) && base_cr;

  // A read is issued only when the output register is free by the time the
  // data comes back, so one read is in flight at most.
  assign rd_en = (state_r == ST_DRAIN) && !rd_pend_r && (!out_valid_r || out_ready);

  clf_line_store #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_fire && is_byte),
    .wr_addr (base_fill),
    .wr_data (in_item.rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt         = state_r;
    fill_count_nxt    = fill_count_r;
    idle_ticks_nxt    = idle_ticks_r;
    prior_cr_nxt      = prior_cr_r;
    idle_timeout_nxt  = idle_timeout_r;
    pending_limit_nxt = pending_limit_r;
    rd_pend_nxt       = 1'b0;
    rd_last_nxt       = rd_last_r;
    out_valid_nxt     = out_valid_r;
    rd_idx_nxt        = rd_idx_r;
    last_idx_nxt      = last_idx_r;
    out_item_nxt      = out_item_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDLE_TIMEOUT:  idle_timeout_nxt  = cfg_data[TIMEOUT_W-1:0];
        CFG_PENDING_LIMIT: pending_limit_nxt = cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end

    if (in_fire) begin
      if (!is_byte) begin
        if (idle_ticks_r != '1) begin
          idle_ticks_nxt = idle_ticks_r + TIMEOUT_W'(1);
        end
      end else begin
        idle_ticks_nxt = '0;
        if (line_done) begin
          fill_count_nxt = '0;
          prior_cr_nxt   = 1'b0;
          last_idx_nxt   = base_fill;
          rd_idx_nxt     = '0;
          state_nxt      = ST_DRAIN;
        end else if (new_fill > eff_limit) begin
          fill_count_nxt = '0;
          prior_cr_nxt   = 1'b0;
        end else begin
          fill_count_nxt = new_fill[AW-1:0];
          prior_cr_nxt   = (in_item.rx_byte == CHAR_CR);
        end
      end
    end

    if (rd_en) begin
      rd_pend_nxt = 1'b1;
      rd_last_nxt = (rd_idx_r == last_idx_r);
      rd_idx_nxt  = rd_idx_r + AW'(1);
      if (rd_idx_r == last_idx_r) begin
        state_nxt = ST_IDLE;
      end
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (rd_pend_r) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.line_byte = rd_data;
      out_item_nxt.line_end  = rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      fill_count_r    <= '0;
      idle_ticks_r    <= '0;
      prior_cr_r      <= 1'b0;
      idle_timeout_r  <= IDLE_TIMEOUT_RST;
      pending_limit_r <= PENDING_LIMIT_RST;
      rd_pend_r       <= 1'b0;
      rd_last_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      fill_count_r    <= fill_count_nxt;
      idle_ticks_r    <= idle_ticks_nxt;
      prior_cr_r      <= prior_cr_nxt;
      idle_timeout_r  <= idle_timeout_nxt;
      pending_limit_r <= pending_limit_nxt;
      rd_pend_r       <= rd_pend_nxt;
      rd_last_r       <= rd_last_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    last_idx_r <= last_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  // Returning read data must never land on a word that is still waiting.
  `ASSERT_PROP(a_rd_into_free_slot, rd_pend_r |-> !out_valid_r, "read data over unsent word")
  // While a line is read out, the fill count and the pending CR stay cleared.
  `ASSERT_NEVER(a_drain_clean, !in_ready && (prior_cr_r || |fill_count_r), "stale state")
  // No input word may be taken while a line is being read out.
  `ASSERT_NEVER(a_no_accept_in_drain, (state_r == ST_DRAIN) && in_ready, "ready in drain")
  // Every accepted byte restarts the idle count.
  `ASSERT_PROP(a_byte_clears_idle, in_fire && is_byte |=> idle_ticks_r == '0, "idle count kept")

endmodule
